FILE: design/wtd_pkg.sv
// shared types and constants for the worker table dispatcher
// no dependencies
package wtd_pkg;

  localparam int unsigned Workers  = 16;
  localparam int unsigned JobTypes = 16;
  localparam int unsigned SlotW    = $clog2(Workers);
  localparam int unsigned CntW     = 5;

  localparam logic [3:0] MODE_REGISTER   = 4'd0;
  localparam logic [3:0] MODE_UNREGISTER = 4'd1;
  localparam logic [3:0] MODE_SET_STATUS = 4'd2;
  localparam logic [3:0] MODE_HEARTBEAT  = 4'd3;
  localparam logic [3:0] MODE_ASSIGN     = 4'd4;
  localparam logic [3:0] MODE_COMPLETE   = 4'd5;
  localparam logic [3:0] MODE_FAIL       = 4'd6;
  localparam logic [3:0] MODE_FIND_IDLE  = 4'd7;
  localparam logic [3:0] MODE_SCAN       = 4'd8;
  localparam logic [3:0] MODE_TICK_FIND  = 4'd9;

  localparam logic [1:0] ST_OFFLINE = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic [1:0] OUT_OK       = 2'd0;
  localparam logic [1:0] OUT_NOTFOUND = 2'd1;
  localparam logic [1:0] OUT_FULL     = 2'd2;

  localparam logic [31:0] TimeoutReset = 32'd30000;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] target_id;
    logic [15:0] conn_handle;
    logic        handle_search;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] type_mask;
    logic [1:0]  new_status;
    logic [15:0] job_number;
    logic [3:0]  job_kind;
    logic [31:0] busy_time_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] result_id;
    logic [4:0]  stale_count;
    logic [4:0]  total_count;
    logic [4:0]  idle_count;
    logic [4:0]  busy_count;
  } rsp_t;

endpackage

FILE: design/worker_table_dispatcher_core.sv
// worker table dispatcher top level: table, sequencer and apb register
// depends on wtd_pkg
//
// usage: a request word is taken when start_i is high and busy_o is low.
// every request yields exactly one result word, shown for one cycle with
// done_o high; the receiver cannot stall it. a request runs a sequencer over
// the sixteen table slots one per cycle using a single shared compare unit:
// register, id lookups, find idle, find by handle and the timeout scan pass
// through a capture state, the walk over the slots, an update state and a
// result state; a millisecond tick and unused modes take the same path. the
// heartbeat timeout register sits at apb address 0.
module worker_table_dispatcher_core import wtd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_UPDATE, S_DONE} state_e;

  // table storage; valid tracked by nonzero id (reset clears ids)
  logic [15:0] id_q      [Workers];
  logic [15:0] handle_q  [Workers];
  logic [31:0] addr_q    [Workers];
  logic [15:0] port_q    [Workers];
  logic [1:0]  status_q  [Workers];
  logic [16:0] job_q     [Workers];
  logic [31:0] seen_q    [Workers];
  logic [15:0] types_q   [Workers];
  logic [31:0] done_q    [Workers];
  logic [31:0] failed_q  [Workers];
  logic [47:0] btotal_q  [Workers];

  state_e      state_q;
  req_t        req_q;
  logic [SlotW-1:0] idx_q;
  logic        hit_q;
  logic [SlotW-1:0] slot_q;
  logic [4:0]  stale_q;
  logic [15:0] next_id_q;
  logic [31:0] now_q;
  logic [4:0]  total_q, idle_q, busy_q;
  logic [31:0] timeout_q;
  rsp_t        rsp_q;
  logic        done_q1;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? timeout_q : 32'd0;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q1;
  assign rsp_o  = rsp_q;

  // shared per-slot compare unit, evaluated on the slot under idx_q
  logic        occ, match, idle_ok, better, stale_hit, id_ok;
  logic [31:0] elapsed;
  logic [15:0] mask_eff;
  always_comb begin
    occ      = (id_q[idx_q] != 16'd0);
    id_ok    = (req_q.target_id != 16'd0) &&
               ((next_id_q == 16'd0) || (req_q.target_id < next_id_q));
    elapsed  = now_q - seen_q[idx_q];
    stale_hit = occ && (elapsed > timeout_q);
    idle_ok  = occ && (status_q[idx_q] == ST_IDLE) &&
               ({1'b0, req_q.job_kind} < 5'(JobTypes)) && types_q[idx_q][req_q.job_kind];
    better   = !hit_q || (done_q[idx_q] < done_q[slot_q]);
    mask_eff = req_q.type_mask;
    match    = 1'b0;
    case (req_q.mode)
      MODE_REGISTER:  match = !occ;
      MODE_FIND_IDLE: match = idle_ok && better;
      MODE_TICK_FIND: match = occ && (handle_q[idx_q] == req_q.conn_handle);
      MODE_UNREGISTER, MODE_SET_STATUS, MODE_HEARTBEAT, MODE_ASSIGN,
      MODE_COMPLETE, MODE_FAIL:
        match = id_ok && occ && (id_q[idx_q] == req_q.target_id);
      default:        match = 1'b0;
    endcase
  end

  // status transition counts for the addressed slot
  logic [1:0] old_st, new_st;
  logic [4:0] idle_n, busy_n;
  always_comb begin
    old_st = status_q[slot_q];
    new_st = ST_OFFLINE;
    case (req_q.mode)
      MODE_SET_STATUS: new_st = (req_q.new_status > ST_BUSY) ? ST_OFFLINE : req_q.new_status;
      MODE_ASSIGN:     new_st = ST_BUSY;
      MODE_COMPLETE, MODE_FAIL: new_st = ST_IDLE;
      default:         new_st = ST_OFFLINE;
    endcase
    idle_n = idle_q;
    busy_n = busy_q;
    if (old_st != new_st) begin
      if (old_st == ST_IDLE && idle_q != 5'd0) idle_n = idle_q - 5'd1;
      else if (old_st == ST_BUSY && busy_q != 5'd0) busy_n = busy_q - 5'd1;
      if (new_st == ST_IDLE) idle_n = idle_n + 5'd1;
      else if (new_st == ST_BUSY) busy_n = busy_n + 5'd1;
    end
  end

  // outcome and id of the result word, from the walk result
  logic [1:0]  outcome_d;
  logic [15:0] rid_d;
  always_comb begin
    outcome_d = OUT_OK;
    rid_d     = '0;
    case (req_q.mode)
      MODE_REGISTER: begin
        if (mask_eff == 16'd0 || !hit_q || next_id_q == 16'd0) outcome_d = OUT_FULL;
        else rid_d = next_id_q;
      end
      MODE_UNREGISTER, MODE_SET_STATUS, MODE_HEARTBEAT, MODE_ASSIGN,
      MODE_COMPLETE, MODE_FAIL: begin
        if (!hit_q) outcome_d = OUT_NOTFOUND;
      end
      MODE_FIND_IDLE: begin
        if (hit_q) rid_d = id_q[slot_q];
        else outcome_d = OUT_NOTFOUND;
      end
      MODE_TICK_FIND: begin
        if (req_q.handle_search) begin
          if (hit_q) rid_d = id_q[slot_q];
          else outcome_d = OUT_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  logic [48:0] bsum;
  assign bsum = {1'b0, btotal_q[slot_q]} + 49'(req_q.busy_time_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      slot_q    <= '0;
      stale_q   <= '0;
      next_id_q <= 16'd1;
      now_q     <= '0;
      total_q   <= '0;
      idle_q    <= '0;
      busy_q    <= '0;
      timeout_q <= TimeoutReset;
      done_q1   <= 1'b0;
      for (int i = 0; i < Workers; i++) begin
        id_q[i]     <= '0;
        handle_q[i] <= '0;
        addr_q[i]   <= '0;
        port_q[i]   <= '0;
        status_q[i] <= ST_OFFLINE;
        job_q[i]    <= '0;
        seen_q[i]   <= '0;
        types_q[i]  <= '0;
        done_q[i]   <= '0;
        failed_q[i] <= '0;
        btotal_q[i] <= '0;
      end
    end else begin
      done_q1 <= (state_q == S_DONE);
      if (psel && penable && pwrite && paddr == 2'd0) timeout_q <= pwdata;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q   <= req_i;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            slot_q  <= '0;
            stale_q <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          // register and handle search keep the first hit; find idle keeps the best
          if (req_q.mode == MODE_SCAN) begin
            if (stale_hit) begin
              stale_q <= stale_q + 5'd1;
              if (status_q[idx_q] != ST_OFFLINE) begin
                status_q[idx_q] <= ST_OFFLINE;
                if (status_q[idx_q] == ST_IDLE && idle_q != 5'd0) idle_q <= idle_q - 5'd1;
                else if (status_q[idx_q] == ST_BUSY && busy_q != 5'd0)
                  busy_q <= busy_q - 5'd1;
              end
            end
          end else if (match && (!hit_q || req_q.mode == MODE_FIND_IDLE)) begin
            hit_q  <= 1'b1;
            slot_q <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == SlotW'(Workers - 1)) state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          rsp_q.outcome     <= outcome_d;
          rsp_q.result_id   <= rid_d;
          rsp_q.stale_count <= (req_q.mode == MODE_SCAN) ? stale_q : 5'd0;
          case (req_q.mode)
            MODE_REGISTER: begin
              if (outcome_d == OUT_OK) begin
                id_q[slot_q]     <= next_id_q;
                next_id_q        <= next_id_q + 16'd1;
                handle_q[slot_q] <= req_q.conn_handle;
                addr_q[slot_q]   <= req_q.peer_address;
                port_q[slot_q]   <= req_q.peer_port;
                status_q[slot_q] <= ST_IDLE;
                job_q[slot_q]    <= 17'h10000;
                seen_q[slot_q]   <= now_q;
                types_q[slot_q]  <= mask_eff;
                done_q[slot_q]   <= '0;
                failed_q[slot_q] <= '0;
                btotal_q[slot_q] <= '0;
                total_q          <= total_q + 5'd1;
                idle_q           <= idle_q + 5'd1;
              end
            end
            MODE_UNREGISTER, MODE_SET_STATUS, MODE_HEARTBEAT, MODE_ASSIGN,
            MODE_COMPLETE, MODE_FAIL: begin
              if (hit_q) begin
                if (req_q.mode != MODE_HEARTBEAT) begin
                  status_q[slot_q] <= new_st;
                  idle_q <= idle_n;
                  busy_q <= busy_n;
                end
                case (req_q.mode)
                  MODE_UNREGISTER: begin
                    if (total_q != 5'd0) total_q <= total_q - 5'd1;
                    id_q[slot_q]     <= '0;
                    handle_q[slot_q] <= '0;
                    addr_q[slot_q]   <= '0;
                    port_q[slot_q]   <= '0;
                    job_q[slot_q]    <= '0;
                    seen_q[slot_q]   <= '0;
                    types_q[slot_q]  <= '0;
                    done_q[slot_q]   <= '0;
                    failed_q[slot_q] <= '0;
                    btotal_q[slot_q] <= '0;
                  end
                  MODE_HEARTBEAT: seen_q[slot_q] <= now_q;
                  MODE_ASSIGN:    job_q[slot_q] <= {1'b0, req_q.job_number};
                  MODE_COMPLETE: begin
                    job_q[slot_q] <= 17'h10000;
                    if (done_q[slot_q] != '1) done_q[slot_q] <= done_q[slot_q] + 32'd1;
                    btotal_q[slot_q] <= bsum[48] ? '1 : bsum[47:0];
                  end
                  MODE_FAIL: begin
                    job_q[slot_q] <= 17'h10000;
                    if (failed_q[slot_q] != '1) failed_q[slot_q] <= failed_q[slot_q] + 32'd1;
                  end
                  default: ;
                endcase
              end
            end
            MODE_TICK_FIND: begin
              if (!req_q.handle_search) now_q <= now_q + 32'd1;
            end
            default: ;
          endcase
          state_q <= S_DONE;
        end
        S_DONE: begin
          rsp_q.total_count <= total_q;
          rsp_q.idle_count  <= idle_q;
          rsp_q.busy_count  <= busy_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
